// ===== design/css_pkg.sv =====
// Package: types, constants and codes shared by the charge session sequencer.
`timescale 1ns / 1ps

package css_pkg;

    // Plug sequence states
    typedef enum logic [1:0] {
        PL_UNPLUGGED = 2'd0,
        PL_UNLOCKED  = 2'd1,
        PL_LOCKED    = 2'd2,
        PL_FAULT     = 2'd3
    } plug_e_t;

    // Charge sequence states
    typedef enum logic [2:0] {
        CS_IDLE      = 3'd0,
        CS_CONNECTED = 3'd1,
        CS_HANDSHAKE = 3'd2,
        CS_CC        = 3'd3,
        CS_CV        = 3'd4,
        CS_COMPLETE  = 3'd5,
        CS_SUSPENDED = 3'd6,
        CS_FAULT     = 3'd7
    } charge_e_t;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_V_START        = 3'd0,
        CFG_V_FULL         = 3'd1,
        CFG_I_CC           = 3'd2,
        CFG_I_TAPER        = 3'd3,
        CFG_MAX_CURRENT_DA = 3'd4
    } cfg_idx_e_t;

    localparam int TIMER_W  = 9;
    localparam int CV_T_W   = 8;
    localparam int MV_W     = 24;
    localparam int MAXC_W   = 16;

    localparam logic [TIMER_W-1:0] TIMER_MAX       = 9'd511;
    localparam logic [TIMER_W-1:0] INSERT_TICKS    = 9'd20;
    localparam logic [TIMER_W-1:0] LOCK_TICKS      = 9'd20;
    localparam logic [TIMER_W-1:0] CONNECT_TICKS   = 9'd20;
    localparam logic [TIMER_W-1:0] HANDSHAKE_TICKS = 9'd30;
    localparam logic [TIMER_W-1:0] CC_TICKS        = 9'd300;
    localparam logic [TIMER_W-1:0] CV_TICKS        = 9'd200;

    localparam logic [5:0] STATUS_PERIOD_TICKS = 6'd20;
    localparam logic [6:0] LIMITS_PERIOD_TICKS = 7'd50;

    // x / 300 = (x >> 2) / 75, and (x >> 2) / 75 = (y * M_CC) >> 38 for y < 2^31
    localparam int          CC_PRE  = 2;
    localparam int          CC_POST = 38;
    localparam logic [31:0] M_CC    = 32'd3665038760;
    // x / 200 = (x >> 3) / 25, and (x >> 3) / 25 = (y * M_CV) >> 34 for y < 2^29
    localparam int          CV_PRE  = 3;
    localparam int          CV_POST = 34;
    localparam logic [29:0] M_CV    = 30'd687194768;

    localparam logic [9:0] ID_STATUS  = 10'h300;
    localparam logic [9:0] ID_LIMITS  = 10'h301;
    localparam logic [3:0] LEN_STATUS = 4'd8;
    localparam logic [3:0] LEN_LIMITS = 4'd4;

    // One tick's frame request, session -> port calculation
    typedef struct packed {
        logic                fire_status;
        logic                fire_limits;
        charge_e_t           chg_state;
        plug_e_t             plug_state;
        logic [TIMER_W-1:0]  phase_timer;
    } css_item_t;

    // Finished frame contents, port calculation -> frame register
    typedef struct packed {
        logic                fire_status;
        logic                fire_limits;
        charge_e_t           chg_state;
        plug_e_t             plug_state;
        logic [MV_W-1:0]     voltage;
        logic [MV_W-1:0]     current;
    } css_port_t;

endpackage

// ===== design/css_session.sv =====
// Plug and charge sequences, tick timers and frame period counters.
`timescale 1ns / 1ps

module css_session (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                accept,
    input  logic                tx_enable,
    input  logic [7:0]          plug_ovr,
    input  logic [7:0]          chg_ovr,
    output logic                item_valid,
    output css_pkg::css_item_t  item
);
    import css_pkg::*;

    plug_e_t             plug_reg, plug_next;
    charge_e_t           charge_reg, charge_next;
    logic [TIMER_W-1:0]  plug_timer_reg, plug_timer_next;
    logic [TIMER_W-1:0]  phase_timer_reg, phase_timer_next;
    logic [4:0]          status_count_reg, status_count_next;
    logic [5:0]          limits_count_reg, limits_count_next;
    logic                prev_enabled_reg, prev_enabled_next;

    plug_e_t             p0, p1;
    charge_e_t           c0, c_tgt, fallback;
    logic [TIMER_W-1:0]  pt0, pt1, ct0, ct1, limit;
    logic [5:0]          status_sum;
    logic [6:0]          limits_sum;
    logic                fire_status, fire_limits;

    // next state
    always_comb begin
        // session restarts on the first enabled tick after a disabled one
        p0  = prev_enabled_reg ? plug_reg : PL_UNPLUGGED;
        c0  = prev_enabled_reg ? charge_reg : CS_IDLE;
        pt0 = prev_enabled_reg ? plug_timer_reg : '0;
        ct0 = prev_enabled_reg ? phase_timer_reg : '0;

        p1  = p0;
        pt1 = pt0;
        if (plug_ovr[7:2] == 6'd0) begin
            if (plug_e_t'(plug_ovr[1:0]) != p0) begin
                p1  = plug_e_t'(plug_ovr[1:0]);
                pt1 = '0;
            end
        end else if (p0 == PL_UNPLUGGED && pt0 >= INSERT_TICKS) begin
            p1  = PL_UNLOCKED;
            pt1 = '0;
        end else if (p0 == PL_UNLOCKED && pt0 >= LOCK_TICKS) begin
            p1  = PL_LOCKED;
            pt1 = '0;
        end

        if (p1 == PL_UNPLUGGED) begin
            fallback = CS_IDLE;
        end else if (p1 == PL_FAULT) begin
            fallback = CS_FAULT;
        end else begin
            fallback = CS_CONNECTED;
        end

        unique case (c0) inside
            CS_CONNECTED: limit = CONNECT_TICKS;
            CS_HANDSHAKE: limit = HANDSHAKE_TICKS;
            CS_CC:        limit = CC_TICKS;
            default:      limit = CV_TICKS;
        endcase

        c_tgt = c0;
        if (chg_ovr[7:3] == 5'd0) begin
            c_tgt = charge_e_t'(chg_ovr[2:0]);
        end else begin
            unique case (c0) inside
                CS_IDLE: begin
                    if (p1 == PL_FAULT) begin
                        c_tgt = CS_FAULT;
                    end else if (p1 != PL_UNPLUGGED) begin
                        c_tgt = CS_CONNECTED;
                    end
                end
                CS_FAULT: begin
                    if (p1 == PL_UNPLUGGED) begin
                        c_tgt = CS_IDLE;
                    end
                end
                CS_COMPLETE, CS_SUSPENDED: begin
                    if (p1 != PL_LOCKED) begin
                        c_tgt = fallback;
                    end
                end
                default: begin
                    if (p1 != PL_LOCKED) begin
                        c_tgt = fallback;
                    end else if (ct0 >= limit) begin
                        c_tgt = charge_e_t'(c0 + 3'd1);
                    end
                end
            endcase
        end

        // entering a new state clears its timer; re-entering the same one does not
        ct1 = (c_tgt != c0) ? '0 : ct0;

        status_sum = {1'b0, status_count_reg} + 6'd1;
        limits_sum = {1'b0, limits_count_reg} + 7'd1;
        fire_status = status_sum >= STATUS_PERIOD_TICKS;
        fire_limits = limits_sum >= LIMITS_PERIOD_TICKS;

        if (tx_enable) begin
            plug_next         = p1;
            charge_next       = c_tgt;
            plug_timer_next   = (pt1 == TIMER_MAX) ? pt1 : pt1 + 9'd1;
            phase_timer_next  = (ct1 == TIMER_MAX) ? ct1 : ct1 + 9'd1;
            status_count_next = fire_status ? 5'(status_sum - STATUS_PERIOD_TICKS)
                                            : status_sum[4:0];
            limits_count_next = fire_limits ? 6'(limits_sum - LIMITS_PERIOD_TICKS)
                                            : limits_sum[5:0];
            prev_enabled_next = 1'b1;
        end else begin
            plug_next         = PL_UNPLUGGED;
            charge_next       = CS_IDLE;
            plug_timer_next   = '0;
            phase_timer_next  = '0;
            status_count_next = '0;
            limits_count_next = '0;
            prev_enabled_next = 1'b0;
        end
    end

    // outputs: frames reflect the state after this tick
    always_comb begin
        item.fire_status  = tx_enable & fire_status;
        item.fire_limits  = tx_enable & fire_limits;
        item.chg_state    = charge_next;
        item.plug_state   = plug_next;
        item.phase_timer  = phase_timer_next;
        item_valid        = item.fire_status | item.fire_limits;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            plug_reg         <= PL_UNPLUGGED;
            charge_reg       <= CS_IDLE;
            plug_timer_reg   <= '0;
            phase_timer_reg  <= '0;
            status_count_reg <= '0;
            limits_count_reg <= '0;
            prev_enabled_reg <= 1'b1;
        end else if (accept) begin
            plug_reg         <= plug_next;
            charge_reg       <= charge_next;
            plug_timer_reg   <= plug_timer_next;
            phase_timer_reg  <= phase_timer_next;
            status_count_reg <= status_count_next;
            limits_count_reg <= limits_count_next;
            prev_enabled_reg <= prev_enabled_next;
        end
    end

endmodule

// ===== design/css_port_calc.sv =====
// Elastic pipeline computing port voltage and current for each frame request.
`timescale 1ns / 1ps

module css_port_calc (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  css_pkg::css_item_t            in_item,
    input  logic [css_pkg::MV_W-1:0]      v_start,
    input  logic [css_pkg::MV_W-1:0]      v_full,
    input  logic [css_pkg::MV_W-1:0]      i_cc,
    input  logic [css_pkg::MV_W-1:0]      i_taper,
    output logic                          out_valid,
    input  logic                          out_ready,
    output css_pkg::css_port_t            out_port
);
    import css_pkg::*;

    // stage 1: clamped times and ramp span
    logic                  v1_reg;
    logic                  fs1_reg, fl1_reg;
    charge_e_t             cs1_reg;
    plug_e_t               pl1_reg;
    logic [TIMER_W-1:0]    tcc1_reg;
    logic [CV_T_W-1:0]     tcv1_reg;
    logic [MV_W-1:0]       d1_reg;
    // stage 2: span * time and taper * time
    logic                  v2_reg;
    logic                  fs2_reg, fl2_reg;
    charge_e_t             cs2_reg;
    plug_e_t               pl2_reg;
    logic [MV_W+TIMER_W-1:0] pcc2_reg;
    logic [MV_W+CV_T_W-1:0]  pcv2_reg;
    // stage 3: reciprocal products
    logic                  v3_reg;
    logic                  fs3_reg, fl3_reg;
    charge_e_t             cs3_reg;
    plug_e_t               pl3_reg;
    logic [62:0]           rcc3_reg;
    logic [58:0]           rcv3_reg;

    logic                  rdy1, rdy2, rdy3;
    logic [MV_W-1:0]       q_cc, q_cv;

    assign rdy3     = !v3_reg || out_ready;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (rdy1) v1_reg <= in_valid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy1) begin
            fs1_reg  <= in_item.fire_status;
            fl1_reg  <= in_item.fire_limits;
            cs1_reg  <= in_item.chg_state;
            pl1_reg  <= in_item.plug_state;
            tcc1_reg <= (in_item.phase_timer > CC_TICKS) ? CC_TICKS : in_item.phase_timer;
            tcv1_reg <= (in_item.phase_timer > CV_TICKS) ? CV_TICKS[CV_T_W-1:0]
                                                         : in_item.phase_timer[CV_T_W-1:0];
            // span saturates at zero when the full level sits below the start
            d1_reg   <= (v_full > v_start) ? v_full - v_start : '0;
        end
        if (rdy2) begin
            fs2_reg  <= fs1_reg;
            fl2_reg  <= fl1_reg;
            cs2_reg  <= cs1_reg;
            pl2_reg  <= pl1_reg;
            pcc2_reg <= d1_reg * tcc1_reg;
            pcv2_reg <= i_taper * tcv1_reg;
        end
        if (rdy3) begin
            fs3_reg  <= fs2_reg;
            fl3_reg  <= fl2_reg;
            cs3_reg  <= cs2_reg;
            pl3_reg  <= pl2_reg;
            rcc3_reg <= pcc2_reg[MV_W+TIMER_W-1:CC_PRE] * M_CC;
            rcv3_reg <= pcv2_reg[MV_W+CV_T_W-1:CV_PRE] * M_CV;
        end
    end

    assign q_cc = rcc3_reg[CC_POST +: MV_W];
    assign q_cv = rcv3_reg[CV_POST +: MV_W];

    always_comb begin
        out_valid             = v3_reg;
        out_port.fire_status  = fs3_reg;
        out_port.fire_limits  = fl3_reg;
        out_port.chg_state    = cs3_reg;
        out_port.plug_state   = pl3_reg;
        case (cs3_reg) inside
            CS_CC: begin
                out_port.voltage = v_start + q_cc;
                out_port.current = i_cc;
            end
            CS_CV: begin
                out_port.voltage = v_full;
                out_port.current = (q_cv >= i_cc) ? '0 : i_cc - q_cv;
            end
            CS_COMPLETE: begin
                out_port.voltage = v_full;
                out_port.current = '0;
            end
            default: begin
                out_port.voltage = '0;
                out_port.current = '0;
            end
        endcase
    end

endmodule

// ===== design/charge_session_sequencer.sv =====
// Top level: charge session sequencer with config registers and frame output register.
// m_tvalid for a tick's first frame rises once the tick has passed the calculation pipeline into the frame register.
// Throughput: one tick per cycle while s_tready is high; a tick that raises both frames sends them
// one after the other from the single frame register, which sends status before limits.
// While m_tready is low up to four frame-carrying ticks wait (three in the calculation
// pipeline, one in the frame register) before s_tready drops.
// Reset (aresetn low, synchronous): config to defaults, session idle, pipeline and output empty.
`timescale 1ns / 1ps

module charge_session_sequencer (
    input  logic        aclk,
    input  logic        aresetn,
    // tick input transaction
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [0] tx_enable, [8:1] plug override, [16:9] state override
    // frame output transaction
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // [3:0] frame_len, [67:4] payload
    output logic [9:0]  m_tuser,   // [9:0] frame_id
    output logic        m_tlast,
    // configuration write transaction
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [23:0] cfg_data
);
    import css_pkg::*;

    // configuration registers
    logic [MV_W-1:0]   pack_start_reg, pack_full_reg, cc_current_reg, cv_taper_reg;
    logic [MAXC_W-1:0] max_current_reg;

    // session -> calc
    logic       s_accept;
    logic       item_valid;
    css_item_t  item;
    logic       calc_in_valid;

    // calc -> frame register
    logic       calc_valid, calc_ready;
    css_port_t  calc_port;

    // frame register: status pending, limits pending, and their contents
    logic             fr_stat_reg, fr_lim_reg;
    charge_e_t        fr_cs_reg;
    plug_e_t          fr_plug_reg;
    logic [MV_W-1:0]  fr_v_reg, fr_i_reg;
    logic             m_accept;
    logic [63:0]      payload;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pack_start_reg  <= 24'd72000;
            pack_full_reg   <= 24'd84000;
            cc_current_reg  <= 24'd10000;
            cv_taper_reg    <= 24'd9500;
            max_current_reg <= 16'd160;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_idx_e_t'(cfg_index))
                CFG_V_START:        pack_start_reg  <= cfg_data;
                CFG_V_FULL:         pack_full_reg   <= cfg_data;
                CFG_I_CC:           cc_current_reg  <= cfg_data;
                CFG_I_TAPER:        cv_taper_reg    <= cfg_data;
                CFG_MAX_CURRENT_DA: max_current_reg <= cfg_data[MAXC_W-1:0];
                default: ;   // unknown index: dropped
            endcase
        end
    end

    // A tick without frames still updates the session; only frame ticks occupy the pipeline.
    assign s_accept      = s_tvalid && s_tready;
    assign calc_in_valid = s_tvalid && item_valid;

    css_session u_session (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .accept      (s_accept),
        .tx_enable   (s_tdata[0]),
        .plug_ovr    (s_tdata[8:1]),
        .chg_ovr     (s_tdata[16:9]),
        .item_valid  (item_valid),
        .item        (item)
    );

    css_port_calc u_calc (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_valid      (calc_in_valid),
        .in_ready      (s_tready),
        .in_item       (item),
        .v_start       (pack_start_reg),
        .v_full        (pack_full_reg),
        .i_cc          (cc_current_reg),
        .i_taper       (cv_taper_reg),
        .out_valid     (calc_valid),
        .out_ready     (calc_ready),
        .out_port      (calc_port)
    );

    // Frame register takes a new tick once its last pending frame leaves.
    assign m_tvalid   = fr_stat_reg | fr_lim_reg;
    assign m_accept   = m_tvalid && m_tready;
    assign calc_ready = !m_tvalid || (m_tready && !(fr_stat_reg && fr_lim_reg));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fr_stat_reg <= 1'b0;
            fr_lim_reg  <= 1'b0;
        end else if (calc_valid && calc_ready) begin
            fr_stat_reg <= calc_port.fire_status;
            fr_lim_reg  <= calc_port.fire_limits;
        end else if (m_accept) begin
            if (fr_stat_reg) begin
                fr_stat_reg <= 1'b0;
            end else begin
                fr_lim_reg  <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (calc_valid && calc_ready) begin
            fr_cs_reg   <= calc_port.chg_state;
            fr_plug_reg <= calc_port.plug_state;
            fr_v_reg    <= calc_port.voltage;
            fr_i_reg    <= calc_port.current;
        end
    end

    // status goes first; last marks the final frame of the tick
    always_comb begin
        if (fr_stat_reg) begin
            payload = {8'd0, fr_i_reg, fr_v_reg, 5'd0, fr_cs_reg};
            m_tuser = ID_STATUS;
            m_tdata = {4'd0, payload, LEN_STATUS};
            m_tlast = !fr_lim_reg;
        end else begin
            payload = {40'd0, max_current_reg, 6'd0, fr_plug_reg};
            m_tuser = ID_LIMITS;
            m_tdata = {4'd0, payload, LEN_LIMITS};
            m_tlast = 1'b1;
        end
    end

endmodule
